[rtl/core/separable_gaussian_blur_top_defines.svh]
// assertion macros for the separable gaussian blur block
`ifndef SEPARABLE_GAUSSIAN_BLUR_TOP_DEFINES_SVH
`define SEPARABLE_GAUSSIAN_BLUR_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// condition that must hold at every clock edge out of reset
`define SGB_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);
// condition that must hold in the cycle after a trigger
`define SGB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SGB_ASSERT(lbl, expr, msg)
`define SGB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/core/sgb_pkg.sv]
// shared types, constants and helpers of the separable gaussian blur
`default_nettype none
package sgb_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_RADIUS = 6;

    localparam int PIX_W      = 8;
    localparam int DIM_W      = 11;
    localparam int COORD_W    = 11;
    localparam int LIN_W      = 22;
    localparam int RAD_W      = 3;
    localparam int DIST_W     = 4;
    localparam int TAP_W      = 17;
    localparam int NUM_W      = 28;
    localparam int DEN_W      = 20;
    localparam int NEAR_W     = 64;
    localparam int FAR_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAPS_NEAR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TAPS_FAR     = 3'd4;

    // reset values of the registers
    localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 11'd1024;
    localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 11'd1024;
    localparam logic [RAD_W-1:0] RST_RADIUS       = 3'd3;

    // input commands
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam logic [TAP_W-1:0] TAP_ONE = 17'h10000;

    // effective configuration after clamping
    typedef struct packed {
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [RAD_W-1:0]  radius;
        logic [NEAR_W-1:0] taps_near;
        logic [FAR_W-1:0]  taps_far;
    } t_cfg;

    // one output pixel to compute
    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last;
    } t_job;

    // weight of the tap at distance d
    function automatic logic [TAP_W-1:0] tap_weight(input logic [DIST_W-1:0] d,
                                                    input logic [NEAR_W-1:0] near,
                                                    input logic [FAR_W-1:0]  far);
        logic [TAP_W-1:0] w;
        w = '0;
        case (d)
            4'd0:    w = TAP_ONE;
            4'd1:    w = {1'b0, near[15:0]};
            4'd2:    w = {1'b0, near[31:16]};
            4'd3:    w = {1'b0, near[47:32]};
            4'd4:    w = {1'b0, near[63:48]};
            4'd5:    w = {1'b0, far[15:0]};
            4'd6:    w = {1'b0, far[31:16]};
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

[rtl/core/sgb_if.sv]
// stream and configuration channel interfaces of the blur block
`default_nettype none
interface sgb_in_if;
    logic                      valid;
    logic                      ready;
    logic                      cmd;
    logic [sgb_pkg::PIX_W-1:0] pixel_in;
    modport source (output valid, output cmd, output pixel_in, input ready);
    modport sink   (input valid, input cmd, input pixel_in, output ready);
endinterface

interface sgb_out_if;
    logic                      valid;
    logic                      ready;
    logic [sgb_pkg::PIX_W-1:0] pixel_out;
    logic                      frame_last;
    modport source (output valid, output pixel_out, output frame_last, input ready);
    modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

interface sgb_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [sgb_pkg::CFG_IDX_W-1:0]  index;
    logic [sgb_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/sgb_ram.sv]
// generic single write port, single read port ram with registered read
`default_nettype none
module sgb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

[rtl/core/sgb_queue.sv]
// short job queue between the front and back parts
`default_nettype none
`include "separable_gaussian_blur_top_defines.svh"
module sgb_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  sgb_pkg::t_job      i_job,
    input  wire logic          i_pop,
    output sgb_pkg::t_job      o_job,
    output logic               o_valid,
    output logic               o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sgb_pkg::t_job   r_slot [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_count;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_job   = r_slot[r_rd];
    assign o_valid = (r_count != '0);
    assign o_empty = (r_count == '0);

    `SGB_ASSERT(a_queue_no_overflow, !(i_push && !i_pop && r_count == CW'(DEPTH)), "queue overflow")
    `SGB_ASSERT(a_queue_no_underflow, !(i_pop && r_count == '0), "queue underflow")
endmodule
`default_nettype wire

[rtl/core/sgb_front.sv]
// front part: takes beats, stores pixels and decides which output is due
`default_nettype none
module sgb_front #(
    parameter int AW = 14
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  sgb_pkg::t_cfg                    i_cfg,
    sgb_in_if.sink                           i_in,
    input  wire logic                        i_hold,
    output logic                             o_push,
    output sgb_pkg::t_job                    o_job,
    output logic                             o_wr_en,
    output logic [AW-1:0]                    o_wr_addr,
    output logic [sgb_pkg::PIX_W-1:0]        o_wr_data
);
    typedef enum logic {F_IDLE, F_EVAL} t_fstate;

    t_fstate                      r_state;
    logic [sgb_pkg::COORD_W-1:0]  r_in_col;
    logic [sgb_pkg::COORD_W-1:0]  r_in_row;
    logic [sgb_pkg::LIN_W-1:0]    r_in_lin;
    logic [sgb_pkg::COORD_W-1:0]  r_out_col;
    logic [sgb_pkg::COORD_W-1:0]  r_out_row;

    logic                         accept;
    logic                         in_frame;
    logic [sgb_pkg::COORD_W:0]    n_in_col;
    logic [sgb_pkg::COORD_W:0]    frow_sum;
    logic [sgb_pkg::COORD_W:0]    fcol_sum;
    logic [sgb_pkg::COORD_W-1:0]  frow;
    logic [sgb_pkg::COORD_W-1:0]  fcol;
    logic [sgb_pkg::LIN_W-1:0]    need;
    logic                         due;
    logic                         last;

    assign i_in.ready = (r_state == F_IDLE) && !i_hold;
    assign accept     = i_in.valid && i_in.ready;
    assign in_frame   = (r_in_row < i_cfg.height);
    assign n_in_col   = {1'b0, r_in_col} + 1'b1;

    // pixel write into the store
    assign o_wr_en   = accept && (i_in.cmd == sgb_pkg::CMD_PIXEL) && in_frame;
    assign o_wr_addr = r_in_lin[AW-1:0];
    assign o_wr_data = i_in.pixel_in;

    // last input pixel the next output depends on
    always_comb begin
        frow_sum = {1'b0, r_out_row} + (sgb_pkg::COORD_W + 1)'(i_cfg.radius);
        fcol_sum = {1'b0, r_out_col} + (sgb_pkg::COORD_W + 1)'(i_cfg.radius);
        frow = (frow_sum > {1'b0, i_cfg.height - 1'b1}) ? i_cfg.height - 1'b1
                                                         : frow_sum[sgb_pkg::COORD_W-1:0];
        fcol = (fcol_sum > {1'b0, i_cfg.width - 1'b1}) ? i_cfg.width - 1'b1
                                                        : fcol_sum[sgb_pkg::COORD_W-1:0];
        need = sgb_pkg::LIN_W'(frow) * sgb_pkg::LIN_W'(i_cfg.width)
             + sgb_pkg::LIN_W'(fcol);
        due  = (r_in_lin > need);
        last = (r_out_row >= i_cfg.height - 1'b1) && (r_out_col >= i_cfg.width - 1'b1);
    end

    assign o_push     = (r_state == F_EVAL) && due;
    assign o_job.row  = r_out_row;
    assign o_job.col  = r_out_col;
    assign o_job.last = last;

    // positions and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= F_IDLE;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_in_lin  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        if (o_wr_en) begin
                            r_in_lin <= r_in_lin + 1'b1;
                            if (n_in_col >= {1'b0, i_cfg.width}) begin
                                r_in_col <= '0;
                                r_in_row <= r_in_row + 1'b1;
                            end else begin
                                r_in_col <= n_in_col[sgb_pkg::COORD_W-1:0];
                            end
                        end
                        r_state <= F_EVAL;
                    end
                end
                F_EVAL: begin
                    if (due) begin
                        if (last) begin
                            r_in_col  <= '0;
                            r_in_row  <= '0;
                            r_in_lin  <= '0;
                            r_out_col <= '0;
                            r_out_row <= '0;
                        end else if ({1'b0, r_out_col} + 1'b1 >= {1'b0, i_cfg.width}) begin
                            r_out_col <= '0;
                            r_out_row <= r_out_row + 1'b1;
                        end else begin
                            r_out_col <= r_out_col + 1'b1;
                        end
                    end
                    r_state <= F_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/core/sgb_back.sv]
// back part: row blur, column blur and the two normalizing divides
`default_nettype none
`include "separable_gaussian_blur_top_defines.svh"
module sgb_back #(
    parameter int AW = 14
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  sgb_pkg::t_cfg                    i_cfg,
    input  sgb_pkg::t_job                    i_job,
    input  wire logic                        i_job_valid,
    output logic                             o_job_pop,
    output logic                             o_rd_en,
    output logic [AW-1:0]                    o_rd_addr,
    input  wire logic [sgb_pkg::PIX_W-1:0]   i_rd_data,
    sgb_out_if.source                        o_out,
    output logic                             o_busy
);
    typedef enum logic [3:0] {
        S_IDLE, S_ROW, S_RD, S_ACC, S_HNEXT, S_HDIV, S_VACC, S_VNEXT, S_VDIV, S_OUT
    } t_bstate;

    localparam int CW = sgb_pkg::COORD_W;

    t_bstate                          r_state;
    sgb_pkg::t_job                    r_job;
    logic [sgb_pkg::DIST_W-1:0]       r_ko;
    logic [sgb_pkg::DIST_W-1:0]       r_kj;
    logic [sgb_pkg::LIN_W-1:0]        r_rowbase;
    logic [sgb_pkg::TAP_W-1:0]        r_wt;
    logic [sgb_pkg::NUM_W-1:0]        r_hnum;
    logic [sgb_pkg::DEN_W-1:0]        r_hden;
    logic [sgb_pkg::NUM_W-1:0]        r_vnum;
    logic [sgb_pkg::DEN_W-1:0]        r_vden;
    logic [sgb_pkg::NUM_W-1:0]        r_rem;
    logic [sgb_pkg::NUM_W-1:0]        r_dsh;
    logic [sgb_pkg::PIX_W-1:0]        r_quo;
    logic [2:0]                       r_dcnt;
    logic                             r_out_valid;
    logic [sgb_pkg::PIX_W-1:0]        r_pix;
    logic                             r_last;

    logic [sgb_pkg::DIST_W-1:0]       rad;
    logic [sgb_pkg::DIST_W-1:0]       span;
    logic [CW:0]                      row_t;
    logic [CW:0]                      col_t;
    logic [CW:0]                      rr_w;
    logic [CW:0]                      cc_w;
    logic                             row_ok;
    logic                             col_ok;
    logic [sgb_pkg::DIST_W-1:0]       dist_h;
    logic [sgb_pkg::DIST_W-1:0]       dist_v;
    logic [sgb_pkg::TAP_W-1:0]        tap_h;
    logic [sgb_pkg::TAP_W-1:0]        tap_v;
    logic [sgb_pkg::LIN_W-1:0]        lin_rd;
    logic                             ge;
    logic                             out_free;

    // window positions and bounds
    always_comb begin
        rad    = sgb_pkg::DIST_W'(i_cfg.radius);
        span   = {rad[sgb_pkg::DIST_W-2:0], 1'b0};
        row_t  = {1'b0, r_job.row} + (CW + 1)'(r_ko);
        col_t  = {1'b0, r_job.col} + (CW + 1)'(r_kj);
        rr_w   = row_t - (CW + 1)'(rad);
        cc_w   = col_t - (CW + 1)'(rad);
        row_ok = (row_t >= (CW + 1)'(rad)) && (rr_w < {1'b0, i_cfg.height});
        col_ok = (col_t >= (CW + 1)'(rad)) && (cc_w < {1'b0, i_cfg.width});
        dist_h = (r_kj >= rad) ? r_kj - rad : rad - r_kj;
        dist_v = (r_ko >= rad) ? r_ko - rad : rad - r_ko;
        tap_h  = sgb_pkg::tap_weight(dist_h, i_cfg.taps_near, i_cfg.taps_far);
        tap_v  = sgb_pkg::tap_weight(dist_v, i_cfg.taps_near, i_cfg.taps_far);
        lin_rd = r_rowbase + sgb_pkg::LIN_W'(cc_w);
        ge     = (r_rem >= r_dsh);
    end

    assign o_rd_en   = (r_state == S_RD) && col_ok;
    assign o_rd_addr = lin_rd[AW-1:0];
    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;
    assign o_busy    = (r_state != S_IDLE);
    assign out_free  = !r_out_valid || o_out.ready;

    assign o_out.valid      = r_out_valid;
    assign o_out.pixel_out  = r_pix;
    assign o_out.frame_last = r_last;

    // sequencer, accumulators, divider and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_out.ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job   <= i_job;
                        r_ko    <= '0;
                        r_vnum  <= '0;
                        r_vden  <= '0;
                        r_state <= S_ROW;
                    end
                end
                S_ROW: begin
                    if (row_ok) begin
                        r_rowbase <= sgb_pkg::LIN_W'(rr_w[CW-1:0])
                                   * sgb_pkg::LIN_W'(i_cfg.width);
                        r_kj      <= '0;
                        r_hnum    <= '0;
                        r_hden    <= '0;
                        r_state   <= S_RD;
                    end else begin
                        r_state <= S_VNEXT;
                    end
                end
                S_RD: begin
                    r_wt    <= tap_h;
                    r_state <= col_ok ? S_ACC : S_HNEXT;
                end
                S_ACC: begin
                    r_hnum  <= r_hnum + sgb_pkg::NUM_W'(i_rd_data) * sgb_pkg::NUM_W'(r_wt);
                    r_hden  <= r_hden + sgb_pkg::DEN_W'(r_wt);
                    r_state <= S_HNEXT;
                end
                S_HNEXT: begin
                    if (r_kj == span) begin
                        r_rem   <= r_hnum;
                        r_dsh   <= {1'b0, r_hden, 7'b0};
                        r_quo   <= '0;
                        r_dcnt  <= '0;
                        r_state <= S_HDIV;
                    end else begin
                        r_kj    <= r_kj + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_HDIV, S_VDIV: begin
                    // one quotient bit a cycle, eight bits in all
                    if (ge) begin
                        r_rem <= r_rem - r_dsh;
                    end
                    r_quo  <= {r_quo[sgb_pkg::PIX_W-2:0], ge};
                    r_dsh  <= r_dsh >> 1;
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == 3'd7) begin
                        r_state <= (r_state == S_HDIV) ? S_VACC : S_OUT;
                    end
                end
                S_VACC: begin
                    r_vnum  <= r_vnum + sgb_pkg::NUM_W'(r_quo) * sgb_pkg::NUM_W'(tap_v);
                    r_vden  <= r_vden + sgb_pkg::DEN_W'(tap_v);
                    r_state <= S_VNEXT;
                end
                S_VNEXT: begin
                    if (r_ko == span) begin
                        r_rem   <= r_vnum;
                        r_dsh   <= {1'b0, r_vden, 7'b0};
                        r_quo   <= '0;
                        r_dcnt  <= '0;
                        r_state <= S_VDIV;
                    end else begin
                        r_ko    <= r_ko + 1'b1;
                        r_state <= S_ROW;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_pix       <= r_quo;
                        r_last      <= r_job.last;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `SGB_ASSERT_NEXT(a_read_consumed, o_rd_en, r_state == S_ACC, "store read not consumed")
    `SGB_ASSERT_NEXT(a_pop_starts_job, o_job_pop, r_state == S_ROW, "popped job not started")
endmodule
`default_nettype wire

[rtl/core/separable_gaussian_blur_top.sv]
// Separable gaussian blur, top level.
// Input channel i_in carries one beat per pixel (cmd = pixel) or per flush tick
// (cmd = flush), in raster order. Output channel o_out carries blurred pixels in
// raster order, with frame_last on the last pixel of a frame. Channel i_cfg writes
// the width, height, radius and tap registers; write it only while idle.
// An output becomes due once the input pixel R rows below and R columns right of
// it (clamped to the frame) is in; flush ticks drain the outputs left at frame end.
// Each input beat passes through the evaluate state of the front part before the
// next is taken. Each output's time in the back part is set by the single read
// port of the pixel store (a tap steps through read, accumulate and next, a tap
// outside the frame skips accumulate) and the divider run after every row sum
// and after the column sum. The next beat is taken once the back part is done
// with the job, so a pixel store slot is never reused early.
// Reset (synchronous, active low) clears positions and the queue and restores the
// register defaults; the pixel store is not cleared. While the receiver stalls the
// output register holds its beat and the block stops taking input once its job
// is done.
`default_nettype none
module separable_gaussian_blur_top #(
    parameter int MAX_WIDTH  = sgb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sgb_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = sgb_pkg::DEF_MAX_RADIUS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sgb_in_if.sink    i_in,
    sgb_out_if.source o_out,
    sgb_cfg_if.sink   i_cfg
);
    localparam int STORE_MIN = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 2;
    localparam int AW        = $clog2(STORE_MIN);
    localparam int DEPTH     = 1 << AW;

    logic [sgb_pkg::DIM_W-1:0]  r_width;
    logic [sgb_pkg::DIM_W-1:0]  r_height;
    logic [sgb_pkg::RAD_W-1:0]  r_radius;
    logic [sgb_pkg::NEAR_W-1:0] r_taps_near;
    logic [sgb_pkg::FAR_W-1:0]  r_taps_far;

    sgb_pkg::t_cfg              cfg;
    sgb_pkg::t_job              push_job;
    sgb_pkg::t_job              head_job;
    logic                       push;
    logic                       pop;
    logic                       head_valid;
    logic                       q_empty;
    logic                       back_busy;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [sgb_pkg::PIX_W-1:0]  wr_data;
    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    logic [sgb_pkg::PIX_W-1:0]  rd_data;

    // configuration registers
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= sgb_pkg::RST_IMAGE_WIDTH;
            r_height    <= sgb_pkg::RST_IMAGE_HEIGHT;
            r_radius    <= sgb_pkg::RST_RADIUS;
            r_taps_near <= '0;
            r_taps_far  <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                sgb_pkg::REG_IMAGE_WIDTH:  r_width     <= i_cfg.data[sgb_pkg::DIM_W-1:0];
                sgb_pkg::REG_IMAGE_HEIGHT: r_height    <= i_cfg.data[sgb_pkg::DIM_W-1:0];
                sgb_pkg::REG_RADIUS:       r_radius    <= i_cfg.data[sgb_pkg::RAD_W-1:0];
                sgb_pkg::REG_TAPS_NEAR:    r_taps_near <= i_cfg.data;
                sgb_pkg::REG_TAPS_FAR:     r_taps_far  <= i_cfg.data[sgb_pkg::FAR_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp to the supported range
    always_comb begin
        cfg.width     = (r_width == '0) ? sgb_pkg::DIM_W'(1)
                      : (r_width > MAX_WIDTH) ? sgb_pkg::DIM_W'(MAX_WIDTH) : r_width;
        cfg.height    = (r_height == '0) ? sgb_pkg::DIM_W'(1)
                      : (r_height > MAX_HEIGHT) ? sgb_pkg::DIM_W'(MAX_HEIGHT) : r_height;
        cfg.radius    = (r_radius > MAX_RADIUS) ? sgb_pkg::RAD_W'(MAX_RADIUS) : r_radius;
        cfg.taps_near = r_taps_near;
        cfg.taps_far  = r_taps_far;
    end

    // front part
    sgb_front #(.AW(AW)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_in      (i_in),
        .i_hold    (!q_empty || back_busy),
        .o_push    (push),
        .o_job     (push_job),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data)
    );

    // job queue
    sgb_queue #(.DEPTH(2)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_valid (head_valid),
        .o_empty (q_empty)
    );

    // pixel store
    sgb_ram #(.WIDTH(sgb_pkg::PIX_W), .DEPTH(DEPTH)) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // back part
    sgb_back #(.AW(AW)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_job       (head_job),
        .i_job_valid (head_valid),
        .o_job_pop   (pop),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_out       (o_out),
        .o_busy      (back_busy)
    );
endmodule
`default_nettype wire

[test/tb.sv]
// testbench of the separable gaussian blur: predicted frames checked beat by beat
`timescale 1ns / 1ps
`default_nettype none
module tb;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int SETTLE_CYCLES  = 700;

    logic i_clk;
    logic i_rst_n;

    sgb_in_if  in_ch ();
    sgb_out_if out_ch ();
    sgb_cfg_if cfg_ch ();

    separable_gaussian_blur_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    typedef struct {
        logic [sgb_pkg::PIX_W-1:0] pixel;
        logic                      last;
    } t_blurred_px;

    // predicted blur state
    logic [sgb_pkg::DIM_W-1:0]  cfg_width;
    logic [sgb_pkg::DIM_W-1:0]  cfg_height;
    logic [sgb_pkg::RAD_W-1:0]  cfg_radius;
    logic [sgb_pkg::NEAR_W-1:0] cfg_near;
    logic [sgb_pkg::FAR_W-1:0]  cfg_far;
    logic [sgb_pkg::PIX_W-1:0]  frame_pix [int];
    int unsigned                in_col, in_row, out_col, out_row;

    t_blurred_px pending_px [$];
    int          fail_count;
    int          pixels_sent;
    int          idle_cycles;
    bit          steady_tx;
    bit          steady_rx;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int unsigned width_eff();
        if (cfg_width < 1) return 1;
        if (cfg_width > sgb_pkg::DEF_MAX_WIDTH) return sgb_pkg::DEF_MAX_WIDTH;
        return cfg_width;
    endfunction

    function automatic int unsigned height_eff();
        if (cfg_height < 1) return 1;
        if (cfg_height > sgb_pkg::DEF_MAX_HEIGHT) return sgb_pkg::DEF_MAX_HEIGHT;
        return cfg_height;
    endfunction

    function automatic int unsigned radius_eff();
        return (cfg_radius > sgb_pkg::DEF_MAX_RADIUS) ? sgb_pkg::DEF_MAX_RADIUS : cfg_radius;
    endfunction

    function automatic logic [63:0] weight_at(int unsigned d);
        if (d == 0) return 64'h10000;
        if (d <= 4) return (cfg_near >> (16 * (d - 1))) & 64'hffff;
        if (d <= 6) return (cfg_far >> (16 * (d - 5))) & 64'hffff;
        return 0;
    endfunction

    // horizontal pass over one row, edges dropped
    function automatic logic [sgb_pkg::PIX_W-1:0] row_smooth(int row, int col);
        logic [63:0] num;
        logic [63:0] den;
        int          cc;
        int          rad;
        num = 0;
        den = 0;
        rad = radius_eff();
        for (int k = -rad; k <= rad; k++) begin
            cc = col + k;
            if (cc < 0 || cc >= int'(width_eff())) continue;
            num += frame_pix[row * width_eff() + cc] * weight_at(k < 0 ? -k : k);
            den += weight_at(k < 0 ? -k : k);
        end
        return (den != 0) ? num / den : 0;
    endfunction

    // vertical pass over row-smoothed values
    function automatic logic [sgb_pkg::PIX_W-1:0] column_smooth(int row, int col);
        logic [63:0] num;
        logic [63:0] den;
        int          rr;
        int          rad;
        num = 0;
        den = 0;
        rad = radius_eff();
        for (int k = -rad; k <= rad; k++) begin
            rr = row + k;
            if (rr < 0 || rr >= int'(height_eff())) continue;
            num += row_smooth(rr, col) * weight_at(k < 0 ? -k : k);
            den += weight_at(k < 0 ? -k : k);
        end
        return (den != 0) ? num / den : 0;
    endfunction

    // advance the blur by one accepted beat, queue the pixel it releases
    function automatic void blur_advance(logic cmd, logic [sgb_pkg::PIX_W-1:0] pix);
        int unsigned w, h, r, got, need, frow, fcol;
        t_blurred_px px;
        w = width_eff();
        h = height_eff();
        r = radius_eff();
        if (cmd == sgb_pkg::CMD_PIXEL && in_row < h) begin
            frame_pix[in_row * w + in_col] = pix;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
        end
        got  = (in_row >= h) ? h * w : in_row * w + in_col;
        frow = (out_row + r > h - 1) ? h - 1 : out_row + r;
        fcol = (out_col + r > w - 1) ? w - 1 : out_col + r;
        need = frow * w + fcol;
        if (got <= need) return;
        px.pixel = column_smooth(out_row, out_col);
        px.last  = (out_row >= h - 1) && (out_col >= w - 1);
        pending_px.push_back(px);
        if (px.last) begin
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
    endfunction

    function automatic bit frame_open();
        return (in_col | in_row | out_col | out_row) != 0;
    endfunction

    // send one beat on the input channel
    task automatic send_beat(logic cmd, logic [sgb_pkg::PIX_W-1:0] pix);
        int gap;
        gap = 0;
        if (!steady_tx && $urandom_range(99) < 23) gap = $urandom_range(4, 1);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.cmd      <= cmd;
        in_ch.pixel_in <= pix;
        do @(posedge i_clk); while (!in_ch.ready);
        blur_advance(cmd, pix);
        if (cmd == sgb_pkg::CMD_PIXEL) pixels_sent++;
    endtask

    // write one register while the block is idle, valid stays up for the next one
    task automatic write_reg(logic [sgb_pkg::CFG_IDX_W-1:0] idx,
                             logic [sgb_pkg::CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            sgb_pkg::REG_IMAGE_WIDTH:  cfg_width  = data[sgb_pkg::DIM_W-1:0];
            sgb_pkg::REG_IMAGE_HEIGHT: cfg_height = data[sgb_pkg::DIM_W-1:0];
            sgb_pkg::REG_RADIUS:       cfg_radius = data[sgb_pkg::RAD_W-1:0];
            sgb_pkg::REG_TAPS_NEAR:    cfg_near   = data[sgb_pkg::NEAR_W-1:0];
            sgb_pkg::REG_TAPS_FAR:     cfg_far    = data[sgb_pkg::FAR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic setup_frame(int w, int h, int r, logic [63:0] near, logic [31:0] far);
        write_reg(sgb_pkg::REG_IMAGE_WIDTH, sgb_pkg::CFG_DATA_W'(w));
        write_reg(sgb_pkg::REG_IMAGE_HEIGHT, sgb_pkg::CFG_DATA_W'(h));
        write_reg(sgb_pkg::REG_RADIUS, sgb_pkg::CFG_DATA_W'(r));
        write_reg(sgb_pkg::REG_TAPS_NEAR, near);
        write_reg(sgb_pkg::REG_TAPS_FAR, {32'h0, far});
        cfg_ch.valid <= 1'b0;
    endtask

    // wait for every predicted pixel, then let the back end go quiet
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pending_px.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [sgb_pkg::PIX_W-1:0] pick_pixel();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hff;
            default: return sgb_pkg::PIX_W'($urandom_range(255));
        endcase
    endfunction

    // stream one whole frame with flush ticks mixed in, then drain it
    task automatic stream_frame(int flush_pct, bit hold_mid);
        int n;
        n = width_eff() * height_eff();
        for (int i = 0; i < n; i++) begin
            while ($urandom_range(99) < flush_pct)
                send_beat(sgb_pkg::CMD_FLUSH, sgb_pkg::PIX_W'($urandom_range(255)));
            if (hold_mid && i == n / 2) begin
                in_ch.valid <= 1'b0;
                do @(posedge i_clk); while (pending_px.size() != 0);
            end
            send_beat(sgb_pkg::CMD_PIXEL, pick_pixel());
        end
        // pixels past the frame end act as flush ticks
        while (frame_open())
            send_beat($urandom_range(4) == 0 ? sgb_pkg::CMD_PIXEL : sgb_pkg::CMD_FLUSH,
                      sgb_pkg::PIX_W'($urandom_range(255)));
        settle();
    endtask

    function automatic logic [63:0] random_taps();
        case ($urandom_range(3))
            0: return 64'h0;
            1: return 64'hffff_ffff_ffff_ffff;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic test_directed();
        // 3x3 frame, full weights: corner and edge windows, extremes of pixel values
        setup_frame(3, 3, 1, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff);
        send_beat(sgb_pkg::CMD_FLUSH, 8'hff);
        send_beat(sgb_pkg::CMD_PIXEL, 8'h00);
        send_beat(sgb_pkg::CMD_PIXEL, 8'hff);
        send_beat(sgb_pkg::CMD_PIXEL, 8'h00);
        send_beat(sgb_pkg::CMD_FLUSH, 8'h00);
        send_beat(sgb_pkg::CMD_PIXEL, 8'hff);
        send_beat(sgb_pkg::CMD_PIXEL, 8'h80);
        send_beat(sgb_pkg::CMD_PIXEL, 8'h01);
        send_beat(sgb_pkg::CMD_PIXEL, 8'hfe);
        send_beat(sgb_pkg::CMD_PIXEL, 8'h7f);
        send_beat(sgb_pkg::CMD_PIXEL, 8'hff);
        while (frame_open()) send_beat(sgb_pkg::CMD_PIXEL, 8'h55);
        settle();
        // width zero acts as one, radius above the maximum clamps
        setup_frame(0, 2, 7, 64'h0001_8000_4000_2000, 32'hffff_0001);
        stream_frame(20, 1'b0);
    endtask

    task automatic test_extreme_sizes();
        // widest row and a tall column, radius zero and one
        setup_frame(2047, 1, 0, 64'h0, 32'h0);
        stream_frame(2, 1'b0);
        setup_frame(1, 300, 1, 64'h8000, 32'h0);
        stream_frame(2, 1'b0);
        // widest window on a small frame
        setup_frame(5, 5, 6, 64'hffff_c000_8000_4000, 32'h2000_1000);
        stream_frame(10, 1'b0);
    endtask

    task automatic test_pause_until_drained();
        setup_frame(6, 5, 2, {$urandom, $urandom}, $urandom);
        stream_frame(10, 1'b1);
    endtask

    task automatic test_random_frames(int target);
        int i;
        i = 0;
        while (pixels_sent < target) begin
            steady_tx = (i % 9 == 4);
            steady_rx = (i % 9 == 4);
            setup_frame($urandom_range(15) == 0 ? 0 : $urandom_range(12, 1),
                        $urandom_range(8, 1), $urandom_range(7),
                        random_taps(), random_taps());
            stream_frame($urandom_range(30), 1'b0);
            i++;
        end
        steady_tx = 1'b0;
        steady_rx = 1'b0;
    endtask

    // receiver stalls and result checking
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (pending_px.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual pixel %0d last %0b",
                             $realtime, out_ch.pixel_out, out_ch.frame_last);
                    fail_count++;
                end else begin
                    if (out_ch.pixel_out !== pending_px[0].pixel) begin
                        $display("%0t: pixel_out expected %0d actual %0d", $realtime,
                                 pending_px[0].pixel, out_ch.pixel_out);
                        fail_count++;
                    end
                    if (out_ch.frame_last !== pending_px[0].last) begin
                        $display("%0t: frame_last expected %0b actual %0b", $realtime,
                                 pending_px[0].last, out_ch.frame_last);
                        fail_count++;
                    end
                    void'(pending_px.pop_front());
                end
            end
            out_ch.ready <= steady_rx || ($urandom_range(99) >= 23);
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("separable_gaussian_blur_top verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.cmd      = sgb_pkg::CMD_FLUSH;
        in_ch.pixel_in = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = sgb_pkg::REG_IMAGE_WIDTH;
        cfg_ch.data    = '0;
        cfg_width      = sgb_pkg::RST_IMAGE_WIDTH;
        cfg_height     = sgb_pkg::RST_IMAGE_HEIGHT;
        cfg_radius     = sgb_pkg::RST_RADIUS;
        cfg_near       = '0;
        cfg_far        = '0;
        in_col         = 0;
        in_row         = 0;
        out_col        = 0;
        out_row        = 0;
        fail_count     = 0;
        pixels_sent    = 0;
        steady_tx      = 1'b0;
        steady_rx      = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_extreme_sizes();
        test_pause_until_drained();
        test_random_frames(pixels_sent + 250);

        settle();
        if (fail_count == 0) begin
            $display("separable_gaussian_blur_top verification clean");
        end else begin
            $display("separable_gaussian_blur_top verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
+incdir+rtl/core
rtl/core/sgb_pkg.sv
rtl/core/sgb_if.sv
rtl/core/sgb_ram.sv
rtl/core/sgb_queue.sv
rtl/core/sgb_front.sv
rtl/core/sgb_back.sv
rtl/core/separable_gaussian_blur_top.sv
test/tb.sv
